// ----- rtl/int32_to_float32_convert_unit_assert.svh -----
// Assertion macros for the integer to single-precision converter.
// Used by the checker module; needs nothing else.
`ifndef INT32_TO_FLOAT32_CONVERT_UNIT_ASSERT_SVH
`define INT32_TO_FLOAT32_CONVERT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2F_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2F_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/i2f_pkg.sv -----
// Shared types, constants and the leading-zero count for the converter.
// No dependencies.
package i2f_pkg;

    localparam int unsigned INT_W   = 32;
    localparam int unsigned FLT_W   = 32;
    localparam int unsigned EXP_W   = 8;
    localparam int unsigned FRAC_W  = 23;
    localparam int unsigned LZC_W   = 5;

    // Bias of the single-precision exponent.
    localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;
    // Biased exponent of a magnitude whose leading one sits at bit 31.
    localparam logic [EXP_W-1:0] EXP_TOP  = 8'd158;
    // Halfway point of the eight discarded bits.
    localparam logic [7:0]       ROUND_HALF = 8'h80;

    typedef logic [INT_W-1:0] word_t;
    typedef logic [EXP_W-1:0] expo_t;
    typedef logic [LZC_W-1:0] lzc_t;

    // Leading-zero count by a five-step binary search; x must not be zero.
    function automatic lzc_t count_lz(input word_t x);
        word_t v;
        lzc_t  n;
        v = x;
        n = '0;
        if (v[31:16] == '0) begin
            n[4] = 1'b1;
            v    = v << 16;
        end
        if (v[31:24] == '0) begin
            n[3] = 1'b1;
            v    = v << 8;
        end
        if (v[31:28] == '0) begin
            n[2] = 1'b1;
            v    = v << 4;
        end
        if (v[31:30] == '0) begin
            n[1] = 1'b1;
            v    = v << 2;
        end
        if (v[31] == 1'b0) begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

// ----- rtl/int32_to_float32_convert_unit.sv -----
// Signed 32-bit integer to IEEE 754 single-precision converter, four stages.
// Depends on i2f_pkg.
//
// One conversion enters per clock cycle while s_ready is high. An accepted
// integer passes through the four register stages in order (negate,
// leading-zero count, normalising shift, round and pack); m_valid is the
// valid bit of the last. Each stage holds its item while the stage after it
// is full and stalled, so empty stages ahead of a stall keep taking input.
// Zero gives +0, the most negative integer gives 0xCF000000 exactly, and the
// eight discarded bits are rounded to nearest, ties to even.
module int32_to_float32_convert_unit
    import i2f_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_float_bits
);

    // Valid bits of the four stages.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage payloads.
    logic  s1_sign_reg, s1_zero_reg;
    word_t s1_mag_reg;
    logic  s2_sign_reg, s2_zero_reg;
    word_t s2_mag_reg;
    lzc_t  s2_lzc_reg;
    logic  s3_sign_reg, s3_zero_reg;
    word_t s3_norm_reg;
    expo_t s3_expo_reg;
    logic [31:0] s4_bits_reg;

    logic  s1_sign_next;
    word_t s1_mag_next;
    logic  round_up;
    logic [EXP_W+FRAC_W-1:0] packed_sum;

    // A stage can load when it is empty or its item moves on.
    assign rdy4 = !v4_reg || m_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_comb begin
        v1_next = rdy1 ? s_valid : v1_reg;
        v2_next = rdy2 ? v1_reg  : v2_reg;
        v3_next = rdy3 ? v2_reg  : v3_reg;
        v4_next = rdy4 ? v3_reg  : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Stage one: sign and magnitude.
    assign s1_sign_next = s_value[31];
    assign s1_mag_next  = s1_sign_next ? (word_t'(0) - word_t'(s_value)) : word_t'(s_value);

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            s1_sign_reg <= s1_sign_next;
            s1_zero_reg <= (s_value == '0);
            s1_mag_reg  <= s1_mag_next;
        end
    end

    // Stage two: leading-zero count of the magnitude.
    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            s2_sign_reg <= s1_sign_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_lzc_reg  <= count_lz(s1_mag_reg);
        end
    end

    // Stage three: normalise so the leading one sits at bit 31.
    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            s3_sign_reg <= s2_sign_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_norm_reg <= s2_mag_reg << s2_lzc_reg;
            s3_expo_reg <= EXP_TOP - expo_t'(s2_lzc_reg);
        end
    end

    // Stage four: round to nearest even; a carry out of the fraction
    // ripples into the exponent field.
    always_comb begin
        round_up = (s3_norm_reg[7:0] > ROUND_HALF)
                || ((s3_norm_reg[7:0] == ROUND_HALF) && s3_norm_reg[8]);
        packed_sum = {s3_expo_reg, s3_norm_reg[30:8]}
                   + {{(EXP_W+FRAC_W-1){1'b0}}, round_up};
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            s4_bits_reg <= s3_zero_reg ? 32'd0 : {s3_sign_reg, packed_sum};
        end
    end

    assign m_valid      = v4_reg;
    assign m_float_bits = s4_bits_reg;

endmodule

// ----- rtl/i2f_assert_check.sv -----
// Port-level checker for the converter, bound to the top level.
// Depends on i2f_pkg and int32_to_float32_convert_unit_assert.svh.
`include "int32_to_float32_convert_unit_assert.svh"

module i2f_assert_check
    import i2f_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_value,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_float_bits
);

    logic [EXP_W-1:0] res_expo;

    assign res_expo = m_float_bits[30:23];

    // The pipeline comes out of reset empty.
    `I2F_ASSERT_SAME(a_empty_after_reset, aclk, aresetn, $past(!aresetn), !m_valid)
    // Input stalls only when a finished result is waiting.
    `I2F_ASSERT_SAME(a_stall_needs_result, aclk, aresetn, !s_ready, m_valid)
    // A result is zero or has an exponent that an integer can produce.
    `I2F_ASSERT_SAME(a_expo_range, aclk, aresetn, m_valid && (m_float_bits != '0),
        (res_expo >= EXP_BIAS) && (res_expo <= EXP_TOP))
    // A stalled result holds its value.
    `I2F_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_float_bits))
    // A stalled input transfer keeps its value until it is taken.
    `I2F_ASSERT_NEXT(a_input_held, aclk, aresetn, s_valid && !s_ready,
        s_valid && $stable(s_value))

endmodule

bind int32_to_float32_convert_unit i2f_assert_check u_i2f_assert_check (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_value      (s_value),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_float_bits (m_float_bits)
);

// ----- bench/int32_to_float32_convert_unit_test.sv -----
// Testbench for the signed integer to single-precision converter.
// Needs i2f_pkg and int32_to_float32_convert_unit; it reads no files.
`timescale 1ns / 100ps

module int32_to_float32_convert_unit_test;
    import i2f_pkg::*;

    // Clock period is 10 ns; the watchdog stops a run that hangs.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned IDLE_PERCENT = 37;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_CYCLES = 20;

    // One accepted conversion: the integer sent and the pattern it must give.
    typedef struct packed {
        word_t       value;
        logic [31:0] bits;
    } conversion_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [31:0]        m_float_bits;

    conversion_t pending_conversions[$];
    conversion_t oldest_conversion;
    bit          idling_enabled = 1'b1;
    int unsigned cycle_count = 0;
    int unsigned sent_count = 0;
    int unsigned checked_count = 0;
    int unsigned negative_count = 0;
    int unsigned mismatch_count = 0;

    int32_to_float32_convert_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_float_bits(m_float_bits)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Single-precision pattern of a two's complement integer, rounded to
    // nearest with ties to even.
    function automatic logic [31:0] single_of_int(input word_t value);
        logic [31:0] magnitude;
        logic [31:0] fraction;
        logic [31:0] exponent_field;
        int          top_bit;
        if (value == '0) begin
            return 32'h0;
        end
        magnitude = value[31] ? (32'h0 - value) : value;
        top_bit = 31;
        while (magnitude[31] == 1'b0) begin
            magnitude = magnitude << 1;
            top_bit--;
        end
        // Drop the hidden one; the eight low bits are the ones rounded away.
        fraction = {1'b0, magnitude[30:0]};
        if (fraction[7:0] > 8'h80 || (fraction[7:0] == 8'h80 && fraction[8])) begin
            fraction = fraction + 32'h100;
        end
        // A carry out of the fraction lands on the exponent's lowest bit.
        exponent_field = (top_bit + 127) << 23;
        return {value[31], 31'h0} + exponent_field + (fraction >> 8);
    endfunction

    // Drives one integer and returns at the edge where it is transferred.
    task automatic send_conversion(input word_t value);
        conversion_t item;
        while (idling_enabled && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        item.value = value;
        item.bits  = single_of_int(value);
        pending_conversions.push_back(item);
        sent_count++;
        if (value[31]) begin
            negative_count++;
        end
    endtask

    task automatic note_mismatch(input string what, input word_t value,
                                 input logic [31:0] want, input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: input %h expected %h got %h",
                     $realtime, what, value, want, got);
        end
    endtask

    // Result side: random back-pressure and a check of every transfer.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_conversions.size() == 0) begin
                note_mismatch("result with nothing outstanding", '0, '0, m_float_bits);
            end else begin
                oldest_conversion = pending_conversions.pop_front();
                checked_count++;
                if (m_float_bits !== oldest_conversion.bits) begin
                    note_mismatch("wrong float_bits", oldest_conversion.value,
                                  oldest_conversion.bits, m_float_bits);
                end
            end
        end
        m_ready <= !(idling_enabled && $urandom_range(99) < IDLE_PERCENT);
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_conversions.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Zero, both signs of one, the extremes, exact powers of two, ties in
    // both directions and fractions that carry into the exponent.
    task automatic test_directed_values();
        word_t corner_values[$];
        corner_values = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                          32'hFFFF_FFFE, 32'h0080_0000, 32'h4000_0000,
                          32'h00FF_FFFF, 32'h0100_0001, 32'h0100_0003,
                          32'h0100_0002, 32'h01FF_FFFF, 32'hFE00_0001,
                          32'h7FFF_FF80, 32'h7FFF_FFC0, 32'h7FFF_FF40,
                          32'h7FFF_FFBF, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h0000_7FFF, 32'hFF00_0000};
        foreach (corner_values[i]) begin
            send_conversion(corner_values[i]);
        end
    endtask

    // Any 32-bit pattern, so every input bit is seen at both levels.
    task automatic test_random_patterns(input int unsigned count);
        repeat (count) begin
            send_conversion($urandom);
        end
    endtask

    // Magnitudes of every length from 1 to 31 bits, so each exponent from 127 to 157 shows up.
    task automatic test_random_lengths(input int unsigned count);
        int unsigned length;
        word_t       magnitude;
        repeat (count) begin
            length = $urandom_range(31, 1);
            magnitude = $urandom & ((32'h1 << length) - 1);
            magnitude[length-1] = 1'b1;
            send_conversion($urandom_range(1) ? (32'h0 - magnitude) : magnitude);
        end
    endtask

    // Normalised patterns, shifted right by one to seven bits, whose rounded-away byte
    // is at or near the halfway point, all ones or random, or whose kept fraction is all ones.
    task automatic test_rounding_boundaries(input int unsigned count);
        logic [7:0]  low_byte;
        logic [22:0] kept;
        word_t       normalised;
        word_t       magnitude;
        repeat (count) begin
            case ($urandom_range(4))
                0: low_byte = 8'h7F;
                1: low_byte = 8'h80;
                2: low_byte = 8'h81;
                3: low_byte = 8'hFF;
                default: low_byte = 8'($urandom);
            endcase
            kept = $urandom_range(3) == 0 ? 23'h7F_FFFF : 23'($urandom);
            normalised = {1'b1, kept, low_byte};
            magnitude = normalised >> $urandom_range(7, 1);
            send_conversion($urandom_range(1) ? (32'h0 - magnitude) : magnitude);
        end
    endtask

    // A back-to-back stretch with both sides always willing.
    task automatic test_full_rate(input int unsigned count);
        idling_enabled = 1'b0;
        test_random_patterns(count / 2);
        test_random_lengths(count - count / 2);
        idling_enabled = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_values();
        test_random_patterns(400);
        test_random_lengths(400);
        test_full_rate(250);
        test_rounding_boundaries(380);

        // Wait for the pipeline to drain, then wait on for stray results.
        s_valid <= 1'b0;
        while (pending_conversions.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d integers (%0d negative), %0d results checked, %0d mismatches",
                 sent_count, negative_count, checked_count, mismatch_count);
        $display("Covered corner values, all exponents, rounding ties and full-rate stretches");
        if (mismatch_count == 0 && pending_conversions.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
